// ===== hw/rtl/ppmu_pkg.sv =====
`default_nettype none

package ppmu_pkg;

  localparam logic signed [31:0] GravityReset = -32'sd642253;
  localparam logic [27:0] OneQ16 = 28'd65536;

  typedef enum logic [0:0] {
    CMD_SPAWN = 1'b0,
    CMD_TICK  = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_READ,
    ST_EVAL,
    ST_MUL,
    ST_POS,
    ST_WB,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    OUT_SPAWN,
    OUT_MID,
    OUT_LAST,
    OUT_EMPTY
  } out_kind_e;

  // one pool entry as stored in the particle memory
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [23:0]        life;
    logic [19:0]        drag;
    logic [31:0]        angle;
    logic signed [31:0] spin;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  typedef struct packed {
    logic      dt_load;
    logic      spawn_we;
    logic      upd_we;
    logic      eval_load;
    logic      mul_load;
    logic      pos_load;
    logic      hold_load;
    logic      out_load;
    out_kind_e out_kind;
    logic      spawn_ok;
  } cmd_t;

  typedef struct packed {
    logic dead;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
    logic signed [31:0] r;
    if (x[41:31] == {11{x[41]}}) begin
      r = x[31:0];
    end else if (x[41]) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppmu_ram.sv =====
`default_nettype none

module ppmu_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppmu_dp.sv =====
`default_nettype none

module ppmu_dp #(
  parameter int PoolSize = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ppmu_pkg::cmd_t              cmd_i,
  output ppmu_pkg::sts_t                   sts_o,
  input  wire logic [$clog2(PoolSize)-1:0] waddr_i,
  input  wire logic [$clog2(PoolSize)-1:0] raddr_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic signed [31:0]          cfg_data_i,
  input  wire logic signed [31:0]          pos_x_i,
  input  wire logic signed [31:0]          pos_y_i,
  input  wire logic signed [31:0]          pos_z_i,
  input  wire logic signed [31:0]          vel_x_i,
  input  wire logic signed [31:0]          vel_y_i,
  input  wire logic signed [31:0]          vel_z_i,
  input  wire logic [23:0]                 lifetime_i,
  input  wire logic [19:0]                 drag_i,
  input  wire logic signed [31:0]          angle_i,
  input  wire logic signed [31:0]          spin_i,
  input  wire logic [23:0]                 dt_i,
  output logic                             has_particle_o,
  output logic signed [31:0]               out_pos_x_o,
  output logic signed [31:0]               out_pos_y_o,
  output logic signed [31:0]               out_pos_z_o,
  output logic signed [31:0]               out_angle_o,
  output logic [23:0]                      life_left_o,
  output logic                             spawn_accepted_o,
  output logic                             last_o
);
  import ppmu_pkg::*;

  logic signed [31:0] grav_q;
  logic [23:0]        dt_q;
  rec_t               rdata, wdata, spawn_rec, upd_rec, cur_q;
  logic               we;

  logic [43:0]        p_kd;
  logic signed [56:0] p_g, p_s, p_px, p_py, p_pz;
  logic signed [49:0] p_vx, p_vy, p_vz;
  logic [27:0]        k_q;
  logic signed [40:0] gdt_q, sdt_q;
  logic [16:0]        f;
  logic signed [31:0] vx_q, vy_q, vz_q, px_q, py_q, pz_q;
  logic [23:0]        life_n_q;
  logic [31:0]        angle_n_q;
  logic signed [41:0] vy_sum;

  logic signed [31:0] hx_q, hy_q, hz_q, ha_q;
  logic [23:0]        hl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GravityReset;
    end else if (cfg_valid_i) begin
      grav_q <= cfg_data_i;
    end
  end

  assign spawn_rec = '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                       vel_x: vel_x_i, vel_y: vel_y_i, vel_z: vel_z_i,
                       life: lifetime_i, drag: drag_i, angle: angle_i, spin: spin_i};
  assign upd_rec   = '{pos_x: px_q, pos_y: py_q, pos_z: pz_q,
                       vel_x: vx_q, vel_y: vy_q, vel_z: vz_q,
                       life: life_n_q, drag: cur_q.drag, angle: angle_n_q,
                       spin: cur_q.spin};
  assign wdata = cmd_i.spawn_we ? spawn_rec : upd_rec;
  assign we    = cmd_i.spawn_we | cmd_i.upd_we;

  ppmu_ram #(.Width(RecW), .Depth(PoolSize)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_i),
    .wdata_i (wdata),
    .raddr_i (raddr_i),
    .rdata_o (rdata)
  );

  assign sts_o.dead = (rdata.life <= dt_q);

  // first products, from the memory read and the gravity register
  assign p_kd = {24'd0, rdata.drag} * {20'd0, dt_q};
  assign p_g  = $signed(grav_q) * $signed({1'b0, dt_q});
  assign p_s  = $signed(rdata.spin) * $signed({1'b0, dt_q});

  // drag factor, clamped at zero
  assign f = (k_q >= OneQ16) ? 17'd0 : 17'(OneQ16 - k_q);

  assign p_vx = $signed(cur_q.vel_x) * $signed({1'b0, f});
  assign p_vy = $signed(cur_q.vel_y) * $signed({1'b0, f});
  assign p_vz = $signed(cur_q.vel_z) * $signed({1'b0, f});
  assign vy_sum = {{10{p_vy[47]}}, p_vy[47:16]} + {gdt_q[40], gdt_q};

  assign p_px = $signed(vx_q) * $signed({1'b0, dt_q});
  assign p_py = $signed(vy_q) * $signed({1'b0, dt_q});
  assign p_pz = $signed(vz_q) * $signed({1'b0, dt_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.dt_load) begin
      dt_q <= dt_i;
    end
    if (cmd_i.eval_load) begin
      cur_q <= rdata;
      k_q   <= p_kd[43:16];
      gdt_q <= p_g[56:16];
      sdt_q <= p_s[56:16];
    end
    if (cmd_i.mul_load) begin
      vx_q      <= p_vx[47:16];
      vy_q      <= sat32(vy_sum);
      vz_q      <= p_vz[47:16];
      life_n_q  <= cur_q.life - dt_q;
      angle_n_q <= cur_q.angle + sdt_q[31:0];
    end
    if (cmd_i.pos_load) begin
      px_q <= sat32({{10{cur_q.pos_x[31]}}, cur_q.pos_x} + {p_px[56], p_px[56:16]});
      py_q <= sat32({{10{cur_q.pos_y[31]}}, cur_q.pos_y} + {p_py[56], p_py[56:16]});
      pz_q <= sat32({{10{cur_q.pos_z[31]}}, cur_q.pos_z} + {p_pz[56], p_pz[56:16]});
    end
    if (cmd_i.hold_load) begin
      hx_q <= px_q;
      hy_q <= py_q;
      hz_q <= pz_q;
      ha_q <= angle_n_q;
      hl_q <= life_n_q;
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_kind)
        OUT_MID, OUT_LAST: begin
          has_particle_o   <= 1'b1;
          out_pos_x_o      <= hx_q;
          out_pos_y_o      <= hy_q;
          out_pos_z_o      <= hz_q;
          out_angle_o      <= ha_q;
          life_left_o      <= hl_q;
          spawn_accepted_o <= 1'b0;
          last_o           <= (cmd_i.out_kind == OUT_LAST);
        end
        default: begin
          has_particle_o   <= 1'b0;
          out_pos_x_o      <= '0;
          out_pos_y_o      <= '0;
          out_pos_z_o      <= '0;
          out_angle_o      <= '0;
          life_left_o      <= '0;
          spawn_accepted_o <= (cmd_i.out_kind == OUT_SPAWN) && cmd_i.spawn_ok;
          last_o           <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ppmu_ctrl.sv =====
`default_nettype none

module ppmu_ctrl #(
  parameter int PoolSize = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        command_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ppmu_pkg::cmd_t                   cmd_o,
  input  wire ppmu_pkg::sts_t              sts_i,
  output logic [$clog2(PoolSize)-1:0]      waddr_o,
  output logic [$clog2(PoolSize)-1:0]      raddr_o
);
  import ppmu_pkg::*;

  localparam int AW = $clog2(PoolSize);
  localparam int CW = $clog2(PoolSize + 1);
  localparam logic [CW-1:0] Full = CW'(PoolSize);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, src_q, src_d;
  logic          hold_q, hold_d, ok_q, ok_d, out_q, out_d;
  logic          accept, out_free;
  logic [CW-1:0] cnt_m1, i_p1;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_q || out_ready_i;
  assign cnt_m1   = cnt_q - CW'(1);
  assign i_p1     = i_q + CW'(1);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_q;
  assign raddr_o     = src_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    src_d   = src_q;
    hold_d  = hold_q;
    ok_d    = ok_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_SPAWN) begin
            ok_d    = (cnt_q < Full);
            cnt_d   = (cnt_q < Full) ? cnt_q + CW'(1) : cnt_q;
            state_d = ST_SPAWN;
          end else begin
            i_d     = '0;
            src_d   = '0;
            hold_d  = 1'b0;
            state_d = (cnt_q == '0) ? ST_FLUSH : ST_READ;
          end
        end
      end
      ST_SPAWN: if (out_free) state_d = ST_IDLE;
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL: begin
        if (sts_i.dead) begin
          // last entry takes the dead slot, same slot looked at again
          cnt_d = cnt_m1;
          if (i_q < cnt_m1) begin
            src_d   = cnt_m1;
            state_d = ST_READ;
          end else begin
            state_d = ST_FLUSH;
          end
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_POS;
      ST_POS: state_d = ST_WB;
      ST_WB: begin
        if (!hold_q || out_free) begin
          hold_d = 1'b1;
          i_d    = i_p1;
          src_d  = i_p1;
          state_d = (i_p1 < cnt_q) ? ST_READ : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          hold_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = OUT_EMPTY;
    cmd_o.spawn_ok = ok_q;
    waddr_o        = i_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.dt_load  = accept && (command_i == CMD_TICK);
        cmd_o.spawn_we = accept && (command_i == CMD_SPAWN) && (cnt_q < Full);
        waddr_o        = cnt_q[AW-1:0];
      end
      ST_SPAWN: begin
        cmd_o.out_load = out_free;
        cmd_o.out_kind = OUT_SPAWN;
      end
      ST_EVAL: cmd_o.eval_load = 1'b1;
      ST_MUL:  cmd_o.mul_load  = 1'b1;
      ST_POS:  cmd_o.pos_load  = 1'b1;
      ST_WB: begin
        if (!hold_q || out_free) begin
          cmd_o.upd_we    = 1'b1;
          cmd_o.hold_load = 1'b1;
          cmd_o.out_load  = hold_q;
          cmd_o.out_kind  = OUT_MID;
        end
      end
      ST_FLUSH: begin
        cmd_o.out_load = out_free;
        cmd_o.out_kind = hold_q ? OUT_LAST : OUT_EMPTY;
      end
      default: ;
    endcase
  end

  assign out_d = cmd_o.out_load ? 1'b1 : (out_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      src_q   <= '0;
      hold_q  <= 1'b0;
      ok_q    <= 1'b0;
      out_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      src_q   <= src_d;
      hold_q  <= hold_d;
      ok_q    <= ok_d;
      out_q   <= out_d;
    end
  end

  // after a death the old last entry sits at index cnt_q and is read from there
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("live count beyond pool size");
  a_read_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> (i_q < cnt_q && src_q <= cnt_q && i_q <= src_q))
    else $error("read outside live entries");
  a_wb_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd_we |-> i_q < cnt_q)
    else $error("write-back outside live entries");
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hold_q)
    else $error("survivor left pending after tick");

endmodule

`default_nettype wire

// ===== hw/rtl/particle_pool_motion_update.sv =====
`default_nettype none

// particle pool with fixed-point euler motion update. a spawn item stores one particle at the
// end of the pool (up to POOL_SIZE entries) and returns one result telling whether it was
// stored; that result may wait on the output. a tick item walks the pool in index order out
// of a single particle memory (one write port, registered read): each survivor goes through
// read, life check, velocity scale, position add and write-back, and each death through read
// and life check; write-back waits on the output while a finished survivor is still held.
// survivors leave one at a time, the last one marked; a tick with none left gives one empty
// result. gravity is a register written on its own channel; the user is to write it only while
// the block is idle, and the block itself does not enforce it.
module particle_pool_motion_update #(
  parameter int POOL_SIZE = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic signed [31:0] cfg_data_i,
  // input items
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               command_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  input  wire logic signed [31:0] vel_z_i,
  input  wire logic [23:0]        lifetime_i,
  input  wire logic [19:0]        drag_i,
  input  wire logic signed [31:0] angle_i,
  input  wire logic signed [31:0] spin_i,
  input  wire logic [23:0]        dt_i,
  // result items
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    has_particle_o,
  output logic signed [31:0]      out_pos_x_o,
  output logic signed [31:0]      out_pos_y_o,
  output logic signed [31:0]      out_pos_z_o,
  output logic signed [31:0]      out_angle_o,
  output logic [23:0]             life_left_o,
  output logic                    spawn_accepted_o,
  output logic                    last_o
);
  import ppmu_pkg::*;

  cmd_t                         cmd;
  sts_t                         sts;
  logic [$clog2(POOL_SIZE)-1:0] waddr, raddr;

  // gravity register is always writable
  assign cfg_ready_o = 1'b1;

  ppmu_ctrl #(.PoolSize(POOL_SIZE)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .waddr_o     (waddr),
    .raddr_o     (raddr)
  );

  ppmu_dp #(.PoolSize(POOL_SIZE)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .waddr_i          (waddr),
    .raddr_i          (raddr),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .vel_x_i          (vel_x_i),
    .vel_y_i          (vel_y_i),
    .vel_z_i          (vel_z_i),
    .lifetime_i       (lifetime_i),
    .drag_i           (drag_i),
    .angle_i          (angle_i),
    .spin_i           (spin_i),
    .dt_i             (dt_i),
    .has_particle_o   (has_particle_o),
    .out_pos_x_o      (out_pos_x_o),
    .out_pos_y_o      (out_pos_y_o),
    .out_pos_z_o      (out_pos_z_o),
    .out_angle_o      (out_angle_o),
    .life_left_o      (life_left_o),
    .spawn_accepted_o (spawn_accepted_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
